>>> rtl/dgrt_pkg.sv
// Shared types and codes for the DDA grid ray traversal block.
// Holds the request queue entry, result codes and default sizes.
// No dependencies.
`default_nettype none

package dgrt_pkg;

  localparam int DEF_MAP_WIDTH  = 64;
  localparam int DEF_MAP_HEIGHT = 64;

  localparam logic [7:0] MAX_STEPS_RESET = 8'd128;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RAY   = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_WALL  = 2'd0;
  localparam logic [1:0] STATUS_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_EXIT  = 2'd2;
  localparam logic [1:0] STATUS_WRITE = 2'd3;

  // Struck face codes.
  localparam logic [1:0] FACE_YPOS = 2'd0;
  localparam logic [1:0] FACE_YNEG = 2'd1;
  localparam logic [1:0] FACE_XPOS = 2'd2;
  localparam logic [1:0] FACE_XNEG = 2'd3;

  // Classified request as it travels from the front end to the walker.
  typedef struct packed {
    logic              req_type;
    logic              start_in_map;
    logic [5:0]        cell_x;
    logic [5:0]        cell_y;
    logic              wall_bit;
    logic [31:0]       init_side_x;
    logic [31:0]       init_side_y;
    logic [31:0]       delta_x;
    logic [31:0]       delta_y;
    logic signed [1:0] step_x;
    logic signed [1:0] step_y;
    logic              ray_x_positive;
    logic              ray_y_positive;
  } q_entry_t;

endpackage

`default_nettype wire

>>> rtl/dgrt_front.sv
// Front end of the ray traversal block: accepts request transactions,
// checks the start cell against the map bounds and queues them.
// Depends on dgrt_pkg.
`default_nettype none

module dgrt_front #(
  parameter int MAP_WIDTH  = dgrt_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = dgrt_pkg::DEF_MAP_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [5:0]        cell_x,
  input  logic [5:0]        cell_y,
  input  logic              wall_bit,
  input  logic [31:0]       side_dist_x_in,
  input  logic [31:0]       side_dist_y_in,
  input  logic [31:0]       delta_x,
  input  logic [31:0]       delta_y,
  input  logic signed [1:0] step_x,
  input  logic signed [1:0] step_y,
  input  logic              ray_x_positive,
  input  logic              ray_y_positive,
  input  logic              hold,
  output logic              q_valid,
  output dgrt_pkg::q_entry_t q_entry,
  input  logic              q_pop
);
  import dgrt_pkg::*;

  localparam int QDEPTH = 2;
  localparam logic [10:0] W_U = 11'(MAP_WIDTH);
  localparam logic [10:0] H_U = 11'(MAP_HEIGHT);

  q_entry_t   qmem [QDEPTH];
  q_entry_t   ent;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;

  always_comb begin
    ent.req_type       = req_type;
    ent.start_in_map   = ({5'b0, cell_x} < W_U) && ({5'b0, cell_y} < H_U);
    ent.cell_x         = cell_x;
    ent.cell_y         = cell_y;
    ent.wall_bit       = wall_bit;
    ent.init_side_x    = side_dist_x_in;
    ent.init_side_y    = side_dist_y_in;
    ent.delta_x        = delta_x;
    ent.delta_y        = delta_y;
    ent.step_x         = step_x;
    ent.step_y         = step_y;
    ent.ray_x_positive = ray_x_positive;
    ent.ray_y_positive = ray_y_positive;
  end

  assign in_stall = hold || (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_entry  = qmem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (q_pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dgrt_back.sv
// Back end of the ray traversal block: owns the wall map, clears it after
// reset, performs map writes and walks rays one grid step per cycle.
// Depends on dgrt_pkg.
`default_nettype none

module dgrt_back #(
  parameter int MAP_WIDTH  = dgrt_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = dgrt_pkg::DEF_MAP_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dgrt_pkg::q_entry_t q_entry,
  output logic               q_pop,
  input  logic [7:0]         max_steps,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         hit_x,
  output logic [5:0]         hit_y,
  output logic [1:0]         face,
  output logic [31:0]        side_dist_x_out,
  output logic [31:0]        side_dist_y_out,
  output logic [1:0]         status
);
  import dgrt_pkg::*;

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  // Coordinate registers also hold a raw out-of-map start cell.
  localparam int CXW   = (XW > 6) ? XW : 6;
  localparam int CYW   = (YW > 6) ? YW : 6;
  localparam logic signed [CXW+1:0] W_S = (CXW+2)'(MAP_WIDTH);
  localparam logic signed [CYW+1:0] H_S = (CYW+2)'(MAP_HEIGHT);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [CXW-1:0]    cur_x;
  logic [CYW-1:0]    cur_y;
  logic [31:0]       sdx;
  logic [31:0]       sdy;
  logic [31:0]       dx;
  logic [31:0]       dy;
  logic signed [1:0] stx;
  logic signed [1:0] sty;
  logic              xpos;
  logic              ypos;
  logic [1:0]        res_face;
  logic [1:0]        res_status;
  logic [7:0]        n;
  logic              pending;

  logic              wall_map [DEPTH];
  logic              rd_bit;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              wdata;
  logic [AW-1:0]     raddr;

  logic              take_x;
  logic [32:0]       sum_x;
  logic [32:0]       sum_y;
  logic [31:0]       sdx_next;
  logic [31:0]       sdy_next;
  logic [1:0]        face_next;
  logic signed [CXW+1:0] nx;
  logic signed [CYW+1:0] ny;
  logic              next_in_map;
  logic              out_free;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  // One grid step: strictly smaller x side distance steps x, ties step y.
  always_comb begin
    take_x   = (sdy > sdx);
    sum_x    = {1'b0, sdx} + {1'b0, dx};
    sum_y    = {1'b0, sdy} + {1'b0, dy};
    sdx_next = sdx;
    sdy_next = sdy;
    nx       = $signed({2'b00, cur_x});
    ny       = $signed({2'b00, cur_y});
    if (take_x) begin
      sdx_next  = sum_x[32] ? '1 : sum_x[31:0];
      nx        = $signed({2'b00, cur_x}) + (CXW+2)'(stx);
      face_next = xpos ? FACE_XPOS : FACE_XNEG;
    end else begin
      sdy_next  = sum_y[32] ? '1 : sum_y[31:0];
      ny        = $signed({2'b00, cur_y}) + (CYW+2)'(sty);
      face_next = ypos ? FACE_YPOS : FACE_YNEG;
    end
    next_in_map = (nx >= 0) && (nx < W_S) && (ny >= 0) && (ny < H_S);
    raddr = AW'(ny[CYW-1:0]) * AW'(MAP_WIDTH) + AW'(nx[CXW-1:0]);
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(q_entry.cell_y) * AW'(MAP_WIDTH) + AW'(q_entry.cell_x);
    wdata = q_entry.wall_bit;
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 1'b0;
    end else if (q_pop && (q_entry.req_type == REQ_WRITE) && q_entry.start_in_map) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wall_map[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_bit <= wall_map[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the done state the output register is handled below.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur_x    <= CXW'(q_entry.cell_x);
            cur_y    <= CYW'(q_entry.cell_y);
            sdx      <= (q_entry.req_type == REQ_WRITE) ? '0 : q_entry.init_side_x;
            sdy      <= (q_entry.req_type == REQ_WRITE) ? '0 : q_entry.init_side_y;
            dx       <= q_entry.delta_x;
            dy       <= q_entry.delta_y;
            stx      <= q_entry.step_x;
            sty      <= q_entry.step_y;
            xpos     <= q_entry.ray_x_positive;
            ypos     <= q_entry.ray_y_positive;
            res_face <= FACE_YPOS;
            n        <= 8'd0;
            pending  <= 1'b0;
            if (q_entry.req_type == REQ_WRITE) begin
              res_status <= STATUS_WRITE;
              state      <= ST_DONE;
            end else if (!q_entry.start_in_map) begin
              res_status <= STATUS_EXIT;
              state      <= ST_DONE;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // rd_bit holds the wall bit of the cell entered on the last step.
          priority if (pending && rd_bit) begin
            res_status <= STATUS_WALL;
            pending    <= 1'b0;
            state      <= ST_DONE;
          end else if (n == max_steps) begin
            res_status <= STATUS_LIMIT;
            pending    <= 1'b0;
            state      <= ST_DONE;
          end else begin
            sdx      <= sdx_next;
            sdy      <= sdy_next;
            res_face <= face_next;
            if (!next_in_map) begin
              res_status <= STATUS_EXIT;
              pending    <= 1'b0;
              state      <= ST_DONE;
            end else begin
              cur_x   <= nx[CXW-1:0];
              cur_y   <= ny[CYW-1:0];
              n       <= n + 8'd1;
              pending <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            hit_x           <= cur_x[5:0];
            hit_y           <= cur_y[5:0];
            face            <= res_face;
            side_dist_x_out <= sdx;
            side_dist_y_out <= sdy;
            status          <= res_status;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/dda_grid_ray_traversal.sv
// DDA grid ray traversal over a one-bit wall map.
//
// Input channel (in_valid / in_stall): each transaction either writes one
// map cell (req_type 0) or casts a ray (req_type 1). Output channel
// (out_valid / out_stall): exactly one result transaction per request, in
// request order. The max_steps register is written through cfg_valid /
// cfg_ready, which is always ready; write it only while the block is idle.
//
// A two-entry queue sits between the input side and the ray walker, so
// new requests are taken while a result waits in the output register.
// A map write result passes through the walker's idle and done states;
// a ray also walks one grid step at a time, and one that ends on a wall
// or the step limit is decided after its last step, since the registered
// map read of a step is tested in the next cycle. The walker takes a new
// request only once a result is loaded, so requests run one at a time.
// After reset the map is cleared one cell per cycle, MAP_WIDTH * MAP_HEIGHT
// cells (4096 by default), with in_stall high; max_steps resets to 128.
// A stalled result holds in the output register; the walker finishes its
// current request and then waits until the register is free.
// Depends on dgrt_pkg, dgrt_front and dgrt_back.
`default_nettype none

module dda_grid_ray_traversal #(
  parameter int MAP_WIDTH  = dgrt_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = dgrt_pkg::DEF_MAP_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        max_steps,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [5:0]        cell_x,
  input  logic [5:0]        cell_y,
  input  logic              wall_bit,
  input  logic [31:0]       side_dist_x_in,
  input  logic [31:0]       side_dist_y_in,
  input  logic [31:0]       delta_x,
  input  logic [31:0]       delta_y,
  input  logic signed [1:0] step_x,
  input  logic signed [1:0] step_y,
  input  logic              ray_x_positive,
  input  logic              ray_y_positive,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        hit_x,
  output logic [5:0]        hit_y,
  output logic [1:0]        face,
  output logic [31:0]       side_dist_x_out,
  output logic [31:0]       side_dist_y_out,
  output logic [1:0]        status
);
  import dgrt_pkg::*;

  logic       [7:0] max_steps_reg;
  logic             clearing;
  logic             q_valid;
  logic             q_pop;
  q_entry_t         q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps_reg <= MAX_STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_steps_reg <= max_steps;
    end
  end

  dgrt_front #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .wall_bit      (wall_bit),
    .side_dist_x_in(side_dist_x_in),
    .side_dist_y_in(side_dist_y_in),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .step_x        (step_x),
    .step_y        (step_y),
    .ray_x_positive(ray_x_positive),
    .ray_y_positive(ray_y_positive),
    .hold          (clearing),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop)
  );

  dgrt_back #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .max_steps      (max_steps_reg),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit_x          (hit_x),
    .hit_y          (hit_y),
    .face           (face),
    .side_dist_x_out(side_dist_x_out),
    .side_dist_y_out(side_dist_y_out),
    .status         (status)
  );

  // No request may enter while the map is being cleared.
  a_stall_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("request accepted during map clearing pass");

  // The clearing pass starts right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clearing)
    else $error("map clearing pass did not start after reset");

  // A write result carries zero distances and the default face.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_WRITE)) |->
      (side_dist_x_out == 32'd0) && (side_dist_y_out == 32'd0) && (face == FACE_YPOS))
    else $error("write result carries ray data");

endmodule

`default_nettype wire
